// ===== design/tcfe_pkg.sv =====
// Package with shared types and constants of the teaching CPU.
package tcfe_pkg;
   localparam int unsigned MemBytesDefault = 256;
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_SETPC = 2'd2;
   localparam logic [1:0] FUNC_EXEC  = 2'd3;
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_OPC  = 2'd1;
   localparam logic [1:0] FAULT_ALU  = 2'd2;
   localparam logic [3:0] OPC_LDI = 4'h0;
   localparam logic [3:0] OPC_LDO = 4'h1;
   localparam logic [3:0] OPC_LDX = 4'h2;
   localparam logic [3:0] OPC_STO = 4'h3;
   localparam logic [3:0] OPC_STX = 4'h4;
   localparam logic [3:0] OPC_BAD = 4'h5;
   localparam logic [3:0] OPC_ALU = 4'h6;
   localparam logic [3:0] OPC_SHF = 4'h7;
   localparam logic [3:0] OPC_BR  = 4'h8;
   localparam logic [3:0] OPC_BEQ = 4'h9;
   localparam logic [3:0] OPC_BGT = 4'ha;
   localparam logic [3:0] OPC_JI  = 4'hb;
   localparam logic [3:0] OPC_JO  = 4'hc;
   localparam logic [3:0] OPC_HLT = 4'hf;
   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  address;
      logic [31:0] value;
   } req_type;
   typedef struct packed {
      logic [7:0]  read_byte;
      logic [31:0] pc_now;
      logic        halted;
      logic [1:0]  fault;
   } rsp_type;
endpackage

// ===== design/tcfe_if.sv =====
// Valid/ready channel interface carrying one payload.
interface tcfe_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/teaching_cpu_fetch_execute.sv =====
// Top level of the teaching CPU: sequencer, register file, byte memory and shared adder.
//
// One request channel (req) and one response channel (rsp), valid/ready;
// a transfer happens when valid and ready are both high.
// Each request gives exactly one response. Set pc and an execute request
// while halted go straight to the response; a memory write or read passes
// one memory step first. Other execute requests fetch two bytes, then either
// decode or read the four immediate bytes of a 6-byte instruction; loads and
// stores then move a data word one byte per cycle through the single
// byte-wide memory port. Address, pc and ALU additions go through one 32-bit
// adder used in turn by each step.
// The block takes one request at a time; req_ready is high only when idle and
// no response waits.
// The response sits in an output register until taken; while the receiver
// stalls, no new request is accepted.
// Synchronous reset clears the registers, pc and halt flag. Memory is not
// cleared: reading a byte before it is written returns an arbitrary value.
module teaching_cpu_fetch_execute #(
   parameter int unsigned MEM_BYTES = tcfe_pkg::MemBytesDefault
) (
   input logic clock,
   input logic reset,
   tcfe_if.sink   req,
   tcfe_if.source rsp
);
   import tcfe_pkg::*;
   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MEM   = 10'b0000000010,
      S_F0    = 10'b0000000100,
      S_F1    = 10'b0000001000,
      S_EXT   = 10'b0000010000,
      S_DEC   = 10'b0000100000,
      S_DATA  = 10'b0001000000,
      S_WB    = 10'b0010000000,
      S_RESP  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] regs_ff [8];
   logic [7:0]  mem [MEM_BYTES];
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   req_type     rq_ff, rq_in;
   rsp_type     out_ff, out_in;
   logic        outv_ff, outv_in;
   logic [7:0]  b0_ff, b0_in, b1_ff, b1_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] addr_ff, addr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  fault_ff, fault_in;
   logic [7:0]  rd_ff;

   // memory port
   logic          m_we;
   logic [31:0]   m_addr;
   logic [7:0]    m_wdata;

   // shared adder
   logic [31:0] add_a, add_b, add_y;
   assign add_y = add_a + add_b;

   // register write port
   logic        r_we;
   logic [2:0]  r_wa;
   logic [31:0] r_wd;

   logic [3:0] opc, op0, op1, op2;
   assign opc = b0_ff[7:4];
   assign op0 = b0_ff[3:0];
   assign op1 = b1_ff[7:4];
   assign op2 = b1_ff[3:0];

   logic is_store, is_load;
   assign is_load  = (opc == OPC_LDO) || (opc == OPC_LDX);
   assign is_store = (opc == OPC_STO) || (opc == OPC_STX);

   always_ff @(posedge clock) begin
      if (m_we) mem[m_addr[AW-1:0]] <= m_wdata;
      rd_ff <= mem[m_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
      end else if (r_we) begin
         regs_ff[r_wa] <= r_wd;
      end
   end

   function automatic logic [31:0] shift_fn(input logic [31:0] x, input logic [7:0] imm);
      logic [7:0]  n;
      logic [31:0] r;
      n = 8'd0 - imm;
      if (imm != 8'd0 && !imm[7]) r = (imm >= 8'd32) ? 32'd0 : (x << imm[4:0]);
      else if (n >= 8'd32) r = {32{x[31]}};
      else r = $signed(x) >>> n[4:0];
      return r;
   endfunction

   assign req.ready = (state_ff == S_IDLE) && !outv_ff;
   assign rsp.valid = outv_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      logic [31:0] s, d, nv;
      logic        take;
      state_in = state_ff;
      pc_in = pc_ff; halt_in = halt_ff; rq_in = rq_ff; out_in = out_ff;
      outv_in = outv_ff; b0_in = b0_ff; b1_in = b1_ff; word_in = word_ff;
      addr_in = addr_ff; cnt_in = cnt_ff; fault_in = fault_ff;
      m_we = 1'b0; m_addr = addr_ff; m_wdata = 8'd0;
      add_a = addr_ff; add_b = 32'd0;
      r_we = 1'b0; r_wa = 3'd0; r_wd = 32'd0;
      s = regs_ff[op1[2:0]]; d = regs_ff[op2[2:0]]; nv = 32'd0; take = 1'b0;
      if (outv_ff && rsp.ready) outv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               rq_in = req.data;
               fault_in = FAULT_NONE;
               addr_in = {24'd0, req.data.address};
               unique case (req.data.func)
                  FUNC_WRITE, FUNC_READ: state_in = S_MEM;
                  FUNC_SETPC: begin
                     pc_in = req.data.value; halt_in = 1'b0; state_in = S_RESP;
                  end
                  FUNC_EXEC: begin
                     addr_in = pc_ff;
                     state_in = halt_ff ? S_RESP : S_F0;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_MEM: begin
            m_we = (rq_ff.func == FUNC_WRITE);
            m_wdata = rq_ff.value[7:0];
            state_in = S_RESP;
         end
         S_F0: begin
            add_b = 32'd1; addr_in = add_y; state_in = S_F1;
         end
         S_F1: begin
            b0_in = rd_ff[7:0];
            add_a = pc_ff; add_b = 32'd2; pc_in = add_y; addr_in = add_y;
            cnt_in = 2'd0;
            if (rd_ff[7:4] == OPC_LDI || rd_ff[7:4] == OPC_JI) state_in = S_EXT;
            else state_in = S_DEC;
         end
         S_EXT: begin
            // Byte two, then immediate bytes, one per cycle; read data is registered.
            add_b = 32'd1; addr_in = add_y;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd0) b1_in = rd_ff[7:0];
            else word_in = {word_ff[23:0], rd_ff[7:0]};
            if (cnt_ff == 2'd3) state_in = S_WB;
         end
         S_DEC: begin
            // The second instruction byte arrives now.
            b1_in = rd_ff[7:0];
            s = regs_ff[rd_ff[6:4]];
            unique case (opc)
               OPC_LDO: begin add_a = {26'd0, op0, 2'b00}; add_b = s; end
               OPC_LDX: begin add_a = regs_ff[op0[2:0]]; add_b = s << 2; end
               OPC_STO: begin add_a = {26'd0, rd_ff[7:4], 2'b00};
                  add_b = regs_ff[rd_ff[2:0]]; end
               OPC_STX: begin add_a = s; add_b = regs_ff[rd_ff[2:0]] << 2; end
               default: ;
            endcase
            addr_in = add_y; cnt_in = 2'd0; word_in = 32'd0;
            state_in = (is_load || is_store) ? S_DATA : S_WB;
         end
         S_DATA: begin
            if (is_store) begin
               nv = regs_ff[op0[2:0]];
               m_we = 1'b1;
               unique case (cnt_ff)
                  2'd0: m_wdata = nv[31:24];
                  2'd1: m_wdata = nv[23:16];
                  2'd2: m_wdata = nv[15:8];
                  default: m_wdata = nv[7:0];
               endcase
               add_b = 32'd1; addr_in = add_y; cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) state_in = S_RESP;
            end else begin
               if (cnt_ff != 2'd0 || fault_ff[0]) word_in = {word_ff[23:0], rd_ff[7:0]};
               add_b = 32'd1; addr_in = add_y; cnt_in = cnt_ff + 2'd1;
               fault_in = {1'b0, 1'b1};
               if (cnt_ff == 2'd3 && fault_ff[0]) begin
                  state_in = S_FIN;
               end
               if (cnt_ff == 2'd3 && !fault_ff[0]) begin
                  // Wrapped one pass: restart counting with the pipeline primed.
                  cnt_in = 2'd0;
               end
            end
         end
         S_FIN: begin
            word_in = {word_ff[23:0], rd_ff[7:0]};
            fault_in = FAULT_NONE;
            state_in = S_WB;
         end
         S_WB: begin
            state_in = S_RESP;
            unique case (opc)
               OPC_LDI: begin
                  nv = {word_ff[23:0], rd_ff[7:0]};
                  r_we = 1'b1; r_wa = op0[2:0]; r_wd = nv;
                  // The address register already points past the immediate word.
                  pc_in = addr_ff;
               end
               OPC_JI: pc_in = {word_ff[23:0], rd_ff[7:0]};
               OPC_LDO, OPC_LDX: begin r_we = 1'b1; r_wa = op2[2:0]; r_wd = word_ff; end
               OPC_STO, OPC_STX: ;
               OPC_ALU: begin
                  r_wa = op2[2:0]; r_we = 1'b1; add_a = d;
                  unique case (op0)
                     4'h0: r_wd = s;
                     4'h1: begin add_b = s; r_wd = add_y; end
                     4'h2: r_wd = s & d;
                     4'h3: begin add_b = 32'd1; r_wd = add_y; end
                     4'h4: begin add_b = 32'd4; r_wd = add_y; end
                     4'h5: begin add_b = 32'hffffffff; r_wd = add_y; end
                     4'h6: begin add_b = 32'hfffffffc; r_wd = add_y; end
                     4'h7: r_wd = ~d;
                     4'hf: begin add_a = pc_ff; add_b = {27'd0, op1, 1'b0};
                        r_wd = add_y; end
                     default: begin r_we = 1'b0; fault_in = FAULT_ALU; end
                  endcase
               end
               OPC_SHF: begin
                  r_we = 1'b1; r_wa = op0[2:0];
                  r_wd = shift_fn(regs_ff[op0[2:0]], b1_ff);
               end
               OPC_BR, OPC_BEQ, OPC_BGT: begin
                  nv = regs_ff[op0[2:0]];
                  take = (opc == OPC_BR) || (opc == OPC_BEQ && nv == 32'd0) ||
                         (opc == OPC_BGT && nv != 32'd0 && !nv[31]);
                  add_a = pc_ff; add_b = {{23{b1_ff[7]}}, b1_ff, 1'b0};
                  if (take) pc_in = add_y;
               end
               OPC_JO: begin
                  add_a = regs_ff[op0[2:0]]; add_b = {23'd0, b1_ff, 1'b0};
                  pc_in = add_y;
               end
               OPC_HLT: if (op0 == 4'd0) halt_in = 1'b1;
               OPC_BAD: fault_in = FAULT_OPC;
               default: ;
            endcase
         end
         S_RESP: begin
            if (!outv_ff) begin
               out_in.read_byte = (rq_ff.func == FUNC_READ) ? rd_ff[7:0] : 8'd0;
               out_in.pc_now = pc_ff;
               out_in.halted = halt_ff;
               out_in.fault = (rq_ff.func == FUNC_EXEC) ? fault_ff : FAULT_NONE;
               outv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; pc_ff <= '0; halt_ff <= 1'b0; outv_ff <= 1'b0;
         cnt_ff <= '0; fault_ff <= '0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; halt_ff <= halt_in;
         outv_ff <= outv_in; cnt_ff <= cnt_in; fault_ff <= fault_in;
      end
      rq_ff <= rq_in; out_ff <= out_in; b0_ff <= b0_in; b1_ff <= b1_in;
      word_ff <= word_in; addr_ff <= addr_in;
   end
endmodule
